@@ sv/lrast_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrast_pkg
// Shared types and constants of the line rasterizer: field widths,
// configuration register indexes, action codes and reset values.
// ============================================================================
package lrast_pkg;

    localparam int PIX_W       = 16;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = CFG_W'(624);
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = CFG_W'(320);

    localparam logic ACTION_START   = 1'b0;
    localparam logic ACTION_ADVANCE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } screen_t;

endpackage
`default_nettype wire

@@ sv/lrast_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrast_cmd_if
// Command channel: start a line from two endpoints or ask for the next pixel.
// ============================================================================
interface lrast_cmd_if;
    import lrast_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [PIX_W-1:0] start_x;
    logic signed [PIX_W-1:0] start_y;
    logic signed [PIX_W-1:0] end_x;
    logic signed [PIX_W-1:0] end_y;

    modport source (
        output valid, action, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, action, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface
`default_nettype wire

@@ sv/lrast_pix_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrast_pix_if
// Pixel channel: one pixel of the line with its bounds flags.
// ============================================================================
interface lrast_pix_if;
    import lrast_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    pixel_inside;
    logic                    all_inside;
    logic                    last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_inside, all_inside, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_inside, all_inside, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

@@ sv/lrast_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrast_queue
// Short first-in first-out queue of decoded words between front and back.
// ============================================================================
module lrast_queue #(
    parameter int WIDTH = 85
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);
    import lrast_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ sv/lrast_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrast_front
// Command front end: takes command words, picks the major axis, orders the
// endpoints and packs the line setup into a queue word.
// ============================================================================
module lrast_front #(
    parameter  int COORD_BITS = 16,
    localparam int ENTRY_W    = 5 * COORD_BITS + 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    lrast_cmd_if.sink               cmd,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output logic      [ENTRY_W-1:0] push_data
);
    import lrast_pkg::*;

    localparam int C = COORD_BITS;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_load;
    logic                action_reg;
    logic signed [C-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [C:0]   dx_reg, dy_reg;

    logic signed [C-1:0] sx_in, sy_in, ex_in, ey_in;
    logic signed [C:0]   dx_in, dy_in;

    logic        [C:0]   adx, ady;
    logic                maj_x;
    logic signed [C:0]   dma, dmi, dmi_dir;
    logic signed [C-1:0] sma, ema, smi, emi;
    logic                swap;
    logic signed [C-1:0] major_origin, major_stop, minor_origin;
    logic        [C-1:0] major_span;
    logic signed [C+1:0] minor_span;
    logic                round_up;

    assign sx_in = C'($unsigned(cmd.start_x));
    assign sy_in = C'($unsigned(cmd.start_y));
    assign ex_in = C'($unsigned(cmd.end_x));
    assign ey_in = C'($unsigned(cmd.end_y));
    assign dx_in = (C+1)'(ex_in) - (C+1)'(sx_in);
    assign dy_in = (C+1)'(ey_in) - (C+1)'(sy_in);

    assign s1_load   = !s1_valid_reg || push_ready;
    assign cmd.ready = s1_load;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && cmd.valid)
        begin
            action_reg <= cmd.action;
            sx_reg     <= sx_in;
            sy_reg     <= sy_in;
            ex_reg     <= ex_in;
            ey_reg     <= ey_in;
            dx_reg     <= dx_in;
            dy_reg     <= dy_in;
        end
    end

    always_comb
    begin
        adx          = dx_reg[C] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
        ady          = dy_reg[C] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
        maj_x        = (dx_reg != '0) && (ady <= adx);
        dma          = maj_x ? dx_reg : dy_reg;
        dmi          = maj_x ? dy_reg : dx_reg;
        sma          = maj_x ? sx_reg : sy_reg;
        ema          = maj_x ? ex_reg : ey_reg;
        smi          = maj_x ? sy_reg : sx_reg;
        emi          = maj_x ? ey_reg : ex_reg;
        swap         = dma[C];
        major_origin = swap ? ema : sma;
        major_stop   = swap ? sma : ema;
        minor_origin = swap ? emi : smi;
        major_span   = C'(maj_x ? adx : ady);
        dmi_dir      = swap ? -dmi : dmi;
        minor_span   = {dmi_dir, 1'b0};
        round_up     = !dmi_dir[C] && (dmi_dir != '0);
    end

    assign push_valid = s1_valid_reg;
    assign push_data  = {action_reg, maj_x, major_origin, major_stop, minor_origin,
                         major_span, minor_span, round_up};

endmodule
`default_nettype wire

@@ sv/lrast_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrast_back
// Pixel stepper: holds the active line, walks the major axis one pixel per
// word with an incremental quotient and remainder on the minor axis, and
// registers each pixel with its bounds flags.
// ============================================================================
module lrast_back #(
    parameter  int COORD_BITS = 16,
    localparam int ENTRY_W    = 5 * COORD_BITS + 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrast_pkg::screen_t screen,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire logic [ENTRY_W-1:0] pop_data,
    lrast_pix_if.source             pixel
);
    import lrast_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int CMP_W = (C + 2 > CFG_W) ? C + 2 : CFG_W;

    logic                e_action;
    logic                e_maj_x;
    logic signed [C-1:0] e_major_origin, e_major_stop, e_minor_origin;
    logic        [C-1:0] e_major_span;
    logic signed [C+1:0] e_minor_span;
    logic                e_round_up;

    logic                active_reg, active_next;
    logic                maj_x_reg, maj_x_next;
    logic signed [C-1:0] major_pos_reg, major_pos_next;
    logic signed [C-1:0] major_stop_reg, major_stop_next;
    logic signed [C-1:0] minor_origin_reg, minor_origin_next;
    logic        [C-1:0] major_span_reg, major_span_next;
    logic signed [C+1:0] minor_span_reg, minor_span_next;
    logic                inside_so_far_reg, inside_so_far_next;
    logic signed [C:0]   quot_reg, quot_next;
    logic        [C:0]   rem_reg, rem_next;

    logic                out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]    px_reg, px_next;
    logic [PIX_W-1:0]    py_reg, py_next;
    logic                pix_inside_reg, pix_inside_next;
    logic                all_inside_reg, all_inside_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                do_pop;
    logic                do_start;
    logic                do_step;
    logic                inc;
    logic signed [C+1:0] minor, major_ext, px, py;
    logic                in_bounds;
    logic                last;
    logic signed [C+2:0] rem_ext, span_ext, den_ext, rem_sum, rem_hi, rem_lo;

    assign {e_action, e_maj_x, e_major_origin, e_major_stop, e_minor_origin,
            e_major_span, e_minor_span, e_round_up} = pop_data;

    assign out_free  = !out_valid_reg || pixel.ready;
    assign pop_ready = (e_action == ACTION_START) || !active_reg || out_free;
    assign do_pop    = pop_valid && pop_ready;
    assign do_start  = do_pop && (e_action == ACTION_START);
    assign do_step   = do_pop && (e_action == ACTION_ADVANCE) && active_reg;

    always_comb
    begin
        inc       = minor_span_reg[C+1] && (rem_reg != '0);
        minor     = (C+2)'(minor_origin_reg) + (C+2)'(quot_reg) + {{(C+1){1'b0}}, inc};
        major_ext = (C+2)'(major_pos_reg);
        px        = maj_x_reg ? major_ext : minor;
        py        = maj_x_reg ? minor : major_ext;
        in_bounds = !px[C+1] && !py[C+1]
                    && (CMP_W'($unsigned(px)) < CMP_W'(screen.width))
                    && (CMP_W'($unsigned(py)) < CMP_W'(screen.height));
        last      = (major_pos_reg == major_stop_reg);
        rem_ext   = $signed({2'b00, rem_reg});
        span_ext  = (C+3)'(minor_span_reg);
        den_ext   = $signed({2'b00, major_span_reg, 1'b0});
        rem_sum   = rem_ext + span_ext;
        rem_hi    = rem_sum - den_ext;
        rem_lo    = rem_sum + den_ext;
    end

    always_comb
    begin
        active_next        = active_reg;
        maj_x_next         = maj_x_reg;
        major_pos_next     = major_pos_reg;
        major_stop_next    = major_stop_reg;
        minor_origin_next  = minor_origin_reg;
        major_span_next    = major_span_reg;
        minor_span_next    = minor_span_reg;
        inside_so_far_next = inside_so_far_reg;
        quot_next          = quot_reg;
        rem_next           = rem_reg;

        if (do_start)
        begin
            active_next        = 1'b1;
            maj_x_next         = e_maj_x;
            major_pos_next     = e_major_origin;
            major_stop_next    = e_major_stop;
            minor_origin_next  = e_minor_origin;
            major_span_next    = e_major_span;
            minor_span_next    = e_minor_span;
            inside_so_far_next = 1'b1;
            quot_next          = '0;
            rem_next           = e_round_up ? {1'b0, e_major_span} : '0;
        end
        else if (do_step)
        begin
            inside_so_far_next = inside_so_far_reg && in_bounds;
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (!rem_hi[C+2])
                begin
                    rem_next  = (C+1)'(rem_hi);
                    quot_next = quot_reg + 1'b1;
                end
                else if (rem_sum[C+2])
                begin
                    rem_next  = (C+1)'(rem_lo);
                    quot_next = quot_reg - 1'b1;
                end
                else
                begin
                    rem_next = (C+1)'(rem_sum);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pix_inside_next = pix_inside_reg;
        all_inside_next = all_inside_reg;
        last_next       = last_reg;
        if (do_step)
        begin
            out_valid_next  = 1'b1;
            px_next         = PIX_W'(px);
            py_next         = PIX_W'(py);
            pix_inside_next = in_bounds;
            all_inside_next = inside_so_far_reg && in_bounds;
            last_next       = last;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            maj_x_reg         <= 1'b0;
            major_pos_reg     <= '0;
            major_stop_reg    <= '0;
            minor_origin_reg  <= '0;
            major_span_reg    <= '0;
            minor_span_reg    <= '0;
            inside_so_far_reg <= 1'b1;
            quot_reg          <= '0;
            rem_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            active_reg        <= active_next;
            maj_x_reg         <= maj_x_next;
            major_pos_reg     <= major_pos_next;
            major_stop_reg    <= major_stop_next;
            minor_origin_reg  <= minor_origin_next;
            major_span_reg    <= major_span_next;
            minor_span_reg    <= minor_span_next;
            inside_so_far_reg <= inside_so_far_next;
            quot_reg          <= quot_next;
            rem_reg           <= rem_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        pix_inside_reg <= pix_inside_next;
        all_inside_reg <= all_inside_next;
        last_reg       <= last_next;
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_x      = px_reg;
    assign pixel.pixel_y      = py_reg;
    assign pixel.pixel_inside = pix_inside_reg;
    assign pixel.all_inside   = all_inside_reg;
    assign pixel.last_pixel   = last_reg;

endmodule
`default_nettype wire

@@ sv/line_rasterizer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// line_rasterizer_top
// Line rasterizer: a start word loads two endpoints, each advance word
// returns the next pixel of the line with its bounds flags.
// ============================================================================
//  channel  | dir | words
//  ---------+-----+-------------------------------------------------------
//  cmd      | in  | action, start_x, start_y, end_x, end_y
//  pixel    | out | pixel_x, pixel_y, pixel_inside, all_inside, last_pixel
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_data (screen_width, height)
//
//  One command word per cycle is sustained while the queue takes words; an
//  advance word reaches the pixel output through the front register, then
//  the queue and the pixel register.
//  The stepper updates quotient and remainder once per cycle unless stalled.
//  Reset clears all control state at once; no clearing pass.
//  A two-word queue between front and stepper absorbs pixel stalls.
// ============================================================================
module line_rasterizer_top #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lrast_cmd_if.sink                            cmd,
    lrast_pix_if.source                          pixel,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lrast_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lrast_pkg::CFG_W-1:0]     cfg_data
);
    import lrast_pkg::*;

    localparam int ENTRY_W = 5 * COORD_BITS + 5;

    screen_t            screen_reg, screen_next;
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    always_comb
    begin
        screen_next = screen_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  screen_next.width  = cfg_data;
                REG_SCREEN_HEIGHT: screen_next.height = cfg_data;
                default:           screen_next        = screen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg.width  <= SCREEN_WIDTH_RST;
            screen_reg.height <= SCREEN_HEIGHT_RST;
        end
        else
        begin
            screen_reg <= screen_next;
        end
    end

    lrast_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lrast_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lrast_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .screen    (screen_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pixel     (pixel)
    );

endmodule
`default_nettype wire
